// ===== hw/rtl/i2c_master_slave_sequencer_assert.svh =====
// Assertion macros for the checker of the two-wire bus sequencer.
`ifndef I2C_MASTER_SLAVE_SEQUENCER_ASSERT_SVH
`define I2C_MASTER_SLAVE_SEQUENCER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define I2CMS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("i2cms: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during rst.
`define I2CMS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("i2cms: next-cycle check failed");

`endif

// ===== hw/rtl/i2cms_pkg.sv =====
// Types, codes and helpers of the two-wire bus sequencer.
package i2cms_pkg;

  // Buffer geometry
  localparam int BUF_DEPTH = 256;
  localparam int ADDR_W    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int POS_W     = 9;
  localparam int CAP_INT   = (BUF_DEPTH < 256) ? BUF_DEPTH : 256;
  localparam logic [POS_W-1:0] LIMIT_CAP = POS_W'(CAP_INT);

  // Reciprocal used to reduce a position modulo the buffer depth
  localparam int SLOT_SH  = 18;
  localparam int SLOT_RCP = ((2 ** SLOT_SH) + BUF_DEPTH - 1) / BUF_DEPTH;
  localparam int RCP_W    = 19;
  localparam int DEP_W    = 17;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_COUNT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_COUNT     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_LIMIT   = 2'd3;

  // Item kinds
  localparam logic [1:0] KIND_STATUS    = 2'd0;
  localparam logic [1:0] KIND_BEGIN     = 2'd1;
  localparam logic [1:0] KIND_BUF_WRITE = 2'd2;
  localparam logic [1:0] KIND_BUF_READ  = 2'd3;

  // Bus commands
  localparam logic [2:0] CMD_NONE       = 3'd0;
  localparam logic [2:0] CMD_START      = 3'd1;
  localparam logic [2:0] CMD_GO_ACK     = 3'd2;
  localparam logic [2:0] CMD_GO_NACK    = 3'd3;
  localparam logic [2:0] CMD_TRANSMIT   = 3'd4;
  localparam logic [2:0] CMD_STOP       = 3'd5;
  localparam logic [2:0] CMD_STOP_START = 3'd6;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] status_code;
    logic [7:0] bus_data;
    logic [1:0] transfer_mode;
    logic [7:0] buffer_index;
    logic [7:0] buffer_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       bus_command;
    logic             send_valid;
    logic [7:0]       send_byte;
    logic             done_valid;
    logic             done_success;
    logic [7:0]       done_status;
    logic [6:0]       done_address;
    logic             busy_res;
    logic [POS_W-1:0] received_length;
    logic [7:0]       read_byte;
  } out_item_t;

  // Map a 9-bit position to a buffer entry (position modulo depth)
  function automatic logic [ADDR_W-1:0] slot(input logic [POS_W-1:0] pos);
    logic [POS_W+RCP_W-1:0] prod;
    logic [POS_W-1:0]       quo;
    logic [POS_W+DEP_W-1:0] rem;
    prod = (POS_W+RCP_W)'(pos) * (POS_W+RCP_W)'(SLOT_RCP);
    quo  = POS_W'(prod >> SLOT_SH);
    rem  = (POS_W+DEP_W)'(pos) - (POS_W+DEP_W)'(quo) * (POS_W+DEP_W)'(BUF_DEPTH);
    return ADDR_W'(rem);
  endfunction

endpackage

// ===== hw/rtl/i2cms_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module i2cms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/i2c_master_slave_sequencer.sv =====
// Top level of the two-wire bus sequencer: item handling, state and byte buffer.
//
//  channel  direction  handshake             payload
//  in       input      in_valid / in_ready   in_item  (i2cms_pkg::in_item_t)
//  out      output     out_valid / out_ready out_item (i2cms_pkg::out_item_t)
//  cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// For each item, the accept cycle issues the buffer read; the execute state then
// uses the read data, writes the buffer and loads the result register.
// One item is in flight at a time; the buffer read/write port pair sets this.
// A result waiting in the output register does not block the next accept; the
// execute state holds while the output register is full and not being taken.
// Synchronous reset clears control state; the buffer is not cleared.
module i2c_master_slave_sequencer (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  i2cms_pkg::in_item_t                  in_item,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output i2cms_pkg::out_item_t                 out_item,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [i2cms_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [i2cms_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // Sequencer states
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  // Transfer modes
  localparam logic [1:0] MODE_WRITE      = 2'd0;
  localparam logic [1:0] MODE_READ       = 2'd1;
  localparam logic [1:0] MODE_WRITE_READ = 2'd2;
  localparam logic [1:0] MODE_RESERVED   = 2'd3;

  // Bus status codes
  localparam logic [7:0] SC_START          = 8'h08;
  localparam logic [7:0] SC_REP_START      = 8'h10;
  localparam logic [7:0] SC_MT_SLA_ACK     = 8'h18;
  localparam logic [7:0] SC_MT_SLA_NACK    = 8'h20;
  localparam logic [7:0] SC_MT_DATA_ACK    = 8'h28;
  localparam logic [7:0] SC_MT_DATA_NACK   = 8'h30;
  localparam logic [7:0] SC_MR_SLA_ACK     = 8'h40;
  localparam logic [7:0] SC_MR_SLA_NACK    = 8'h48;
  localparam logic [7:0] SC_MR_DATA_ACK    = 8'h50;
  localparam logic [7:0] SC_MR_DATA_NACK   = 8'h58;
  localparam logic [7:0] SC_SR_SLA_ACK     = 8'h60;
  localparam logic [7:0] SC_SR_ARB_SLA     = 8'h68;
  localparam logic [7:0] SC_SR_GCALL_ACK   = 8'h70;
  localparam logic [7:0] SC_SR_ARB_GCALL   = 8'h78;
  localparam logic [7:0] SC_SR_DATA_ACK    = 8'h80;
  localparam logic [7:0] SC_SR_DATA_NACK   = 8'h88;
  localparam logic [7:0] SC_SR_GDATA_ACK   = 8'h90;
  localparam logic [7:0] SC_SR_GDATA_NACK  = 8'h98;
  localparam logic [7:0] SC_SR_STOP        = 8'hA0;
  localparam logic [7:0] SC_ST_SLA_ACK     = 8'hA8;
  localparam logic [7:0] SC_ST_ARB_SLA     = 8'hB0;
  localparam logic [7:0] SC_ST_DATA_ACK    = 8'hB8;
  localparam logic [7:0] SC_ST_DATA_NACK   = 8'hC0;
  localparam logic [7:0] SC_ST_LAST_DATA   = 8'hC8;

  localparam int PW = i2cms_pkg::POS_W;
  localparam int AW = i2cms_pkg::ADDR_W;

  // Control and configuration registers
  logic                 state;
  i2cms_pkg::in_item_t  item;
  logic [6:0]           target_address;
  logic [PW-1:0]        write_count;
  logic [PW-1:0]        read_count;
  logic [PW-1:0]        buffer_limit;

  // Sequencer state registers
  logic [PW-1:0] buffer_position,  buffer_position_next;
  logic          master_direction, master_direction_next;
  logic [1:0]    operation_mode,   operation_mode_next;
  logic [PW-1:0] send_length,      send_length_next;
  logic [PW-1:0] receive_length,   receive_length_next;
  logic [6:0]    matched_address,  matched_address_next;
  logic          busy_flag,        busy_flag_next;
  logic [PW-1:0] slave_count,      slave_count_next;

  i2cms_pkg::out_item_t res;

  // Buffer port signals
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  logic          wr_req;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;

  logic          accept;
  logic          exec_go;
  logic [PW-1:0] lim;
  logic [PW-1:0] wc_clamp;
  logic [PW-1:0] rc_base;
  logic [PW-1:0] rc_clamp;
  logic [PW-1:0] pos_inc;
  logic [PW-1:0] pos_rx;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign exec_go   = (state == ST_EXEC) && (!out_valid || out_ready);

  // Issue the buffer read for the accepted item
  always_comb begin
    rd_en = accept;
    if (in_item.kind == i2cms_pkg::KIND_BUF_READ) begin
      rd_addr = i2cms_pkg::slot({1'b0, in_item.buffer_index});
    end else if (in_item.status_code inside {SC_ST_SLA_ACK, SC_ST_ARB_SLA}) begin
      rd_addr = '0;
    end else begin
      rd_addr = i2cms_pkg::slot(buffer_position);
    end
  end

  i2cms_ram #(
    .WIDTH(8),
    .DEPTH(i2cms_pkg::BUF_DEPTH)
  ) u_buf (
    .clk   (clk),
    .we    (wr_req && exec_go),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Effective limit and clamped counts
  always_comb begin
    if (buffer_limit == '0) begin
      lim = PW'(1);
    end else if (buffer_limit > i2cms_pkg::LIMIT_CAP) begin
      lim = i2cms_pkg::LIMIT_CAP;
    end else begin
      lim = buffer_limit;
    end
    wc_clamp = (write_count > lim) ? lim : write_count;
    rc_base  = (read_count == '0) ? PW'(1) : read_count;
    rc_clamp = (rc_base > lim) ? lim : rc_base;
  end

  assign pos_inc = buffer_position + PW'(1);
  assign pos_rx  = (item.status_code == SC_MR_DATA_ACK) ? pos_inc : buffer_position;

  // Work out the result and the next state of the held item
  always_comb begin
    buffer_position_next  = buffer_position;
    master_direction_next = master_direction;
    operation_mode_next   = operation_mode;
    send_length_next      = send_length;
    receive_length_next   = receive_length;
    matched_address_next  = matched_address;
    busy_flag_next        = busy_flag;
    slave_count_next      = slave_count;
    wr_req  = 1'b0;
    wr_addr = i2cms_pkg::slot(buffer_position);
    wr_data = item.bus_data;
    res     = '0;

    case (item.kind)
      i2cms_pkg::KIND_BEGIN: begin
        if (item.transfer_mode != MODE_RESERVED) begin
          busy_flag_next      = 1'b1;
          operation_mode_next = item.transfer_mode;
          if (item.transfer_mode != MODE_READ) begin
            send_length_next = wc_clamp;
          end
          if (item.transfer_mode != MODE_WRITE) begin
            receive_length_next = rc_clamp;
          end
          master_direction_next = (item.transfer_mode == MODE_READ);
          res.bus_command       = i2cms_pkg::CMD_START;
        end
      end
      i2cms_pkg::KIND_BUF_WRITE: begin
        wr_req  = 1'b1;
        wr_addr = i2cms_pkg::slot({1'b0, item.buffer_index});
        wr_data = item.buffer_byte;
      end
      i2cms_pkg::KIND_BUF_READ: begin
        res.read_byte = rd_data;
      end
      default: begin
        case (item.status_code)
          SC_START, SC_REP_START: begin
            buffer_position_next = '0;
            res.send_valid  = 1'b1;
            res.send_byte   = {target_address, master_direction};
            res.bus_command = i2cms_pkg::CMD_GO_ACK;
          end
          SC_MT_SLA_ACK, SC_MT_DATA_ACK: begin
            if (buffer_position == send_length) begin
              if (operation_mode == MODE_WRITE_READ) begin
                master_direction_next = 1'b1;
                res.bus_command       = i2cms_pkg::CMD_START;
              end else begin
                res.done_valid   = 1'b1;
                res.done_success = 1'b1;
                res.bus_command  = i2cms_pkg::CMD_STOP;
                busy_flag_next   = 1'b0;
              end
            end else begin
              res.send_valid       = 1'b1;
              res.send_byte        = rd_data;
              buffer_position_next = pos_inc;
              res.bus_command      = i2cms_pkg::CMD_TRANSMIT;
            end
          end
          SC_MR_DATA_ACK, SC_MR_SLA_ACK: begin
            if (item.status_code == SC_MR_DATA_ACK) begin
              wr_req = 1'b1;
            end
            buffer_position_next = pos_rx;
            res.bus_command = (pos_rx == PW'(receive_length - PW'(1))) ?
                              i2cms_pkg::CMD_GO_NACK : i2cms_pkg::CMD_GO_ACK;
          end
          SC_MR_DATA_NACK: begin
            wr_req               = 1'b1;
            buffer_position_next = pos_inc;
            res.done_valid       = 1'b1;
            res.done_success     = 1'b1;
            res.bus_command      = i2cms_pkg::CMD_STOP;
            busy_flag_next       = 1'b0;
          end
          SC_SR_SLA_ACK, SC_SR_ARB_SLA, SC_SR_GCALL_ACK, SC_SR_ARB_GCALL: begin
            matched_address_next = item.bus_data[7:1];
            buffer_position_next = '0;
            res.bus_command      = i2cms_pkg::CMD_GO_ACK;
          end
          SC_SR_DATA_ACK, SC_SR_GDATA_ACK: begin
            if (buffer_position < lim) begin
              wr_req               = 1'b1;
              buffer_position_next = pos_inc;
            end
            res.bus_command = i2cms_pkg::CMD_GO_ACK;
          end
          SC_SR_STOP: begin
            slave_count_next = buffer_position;
            res.done_valid   = 1'b1;
            res.done_success = 1'b1;
            res.done_address = matched_address;
            res.bus_command  = i2cms_pkg::CMD_GO_ACK;
          end
          SC_ST_SLA_ACK, SC_ST_ARB_SLA: begin
            // Address phase restarts the buffer; entry zero was read
            matched_address_next = item.bus_data[7:1];
            res.send_valid       = 1'b1;
            res.send_byte        = rd_data;
            buffer_position_next = PW'(1);
            res.bus_command      = i2cms_pkg::CMD_GO_ACK;
          end
          SC_ST_DATA_ACK: begin
            if (buffer_position < lim) begin
              res.send_valid       = 1'b1;
              res.send_byte        = rd_data;
              buffer_position_next = pos_inc;
            end
            res.bus_command = i2cms_pkg::CMD_GO_ACK;
          end
          SC_SR_DATA_NACK, SC_SR_GDATA_NACK, SC_ST_DATA_NACK, SC_ST_LAST_DATA: begin
            res.bus_command = i2cms_pkg::CMD_GO_ACK;
          end
          SC_MT_SLA_NACK, SC_MT_DATA_NACK, SC_MR_SLA_NACK: begin
            res.done_valid   = 1'b1;
            res.done_status  = item.status_code;
            res.done_address = matched_address;
            res.bus_command  = i2cms_pkg::CMD_STOP_START;
          end
          default: begin
            res.bus_command = i2cms_pkg::CMD_STOP_START;
          end
        endcase
      end
    endcase

    res.busy_res        = busy_flag_next;
    res.received_length = slave_count_next;
  end

  // Advance the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else if (accept) begin
      state <= ST_EXEC;
    end else if (exec_go) begin
      state <= ST_IDLE;
    end
  end

  // Hold the accepted item
  always_ff @(posedge clk) begin
    if (accept) begin
      item <= in_item;
    end
  end

  // Commit state of the finished item
  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_position  <= '0;
      master_direction <= 1'b0;
      operation_mode   <= MODE_WRITE;
      send_length      <= '0;
      receive_length   <= '0;
      matched_address  <= '0;
      busy_flag        <= 1'b0;
      slave_count      <= '0;
    end else if (exec_go) begin
      buffer_position  <= buffer_position_next;
      master_direction <= master_direction_next;
      operation_mode   <= operation_mode_next;
      send_length      <= send_length_next;
      receive_length   <= receive_length_next;
      matched_address  <= matched_address_next;
      busy_flag        <= busy_flag_next;
      slave_count      <= slave_count_next;
    end
  end

  // Output register: load on finish, drop on take
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      out_item <= res;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      target_address <= '0;
      write_count    <= '0;
      read_count     <= PW'(1);
      buffer_limit   <= PW'(256);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        i2cms_pkg::CFG_TARGET_ADDRESS: target_address <= cfg_data[6:0];
        i2cms_pkg::CFG_WRITE_COUNT:    write_count    <= cfg_data;
        i2cms_pkg::CFG_READ_COUNT:     read_count     <= cfg_data;
        i2cms_pkg::CFG_BUFFER_LIMIT:   buffer_limit   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/i2cms_check.sv =====
// Port-level checker of the two-wire bus sequencer and its bind.
`include "i2c_master_slave_sequencer_assert.svh"

module i2cms_check (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input i2cms_pkg::out_item_t out_item
);

  // A pending result stays offered
  `I2CMS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)

  // One item in flight: no accept right after an accept
  `I2CMS_ASSERT_NXT(a_one_item, in_valid && in_ready, !in_ready)

  // No byte shown unless it is to be loaded
  `I2CMS_ASSERT_IMP(a_send_zero, out_valid && !out_item.send_valid, out_item.send_byte == 8'h00)

  // Success is a completion with a clear status
  `I2CMS_ASSERT_IMP(a_done_ok, out_valid && out_item.done_success,
                    out_item.done_valid && (out_item.done_status == 8'h00))

  // Transmit always carries a byte
  `I2CMS_ASSERT_IMP(a_tx_byte, out_valid && (out_item.bus_command == i2cms_pkg::CMD_TRANSMIT),
                    out_item.send_valid)

endmodule

bind i2c_master_slave_sequencer i2cms_check u_i2cms_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the two-wire bus sequencer, with an item-level predictor.
module tb_top;

  // Standard two-wire status codes
  localparam logic [7:0] ST_BUS_ERROR      = 8'h00;
  localparam logic [7:0] ST_START          = 8'h08;
  localparam logic [7:0] ST_REP_START      = 8'h10;
  localparam logic [7:0] ST_MT_SLA_ACK     = 8'h18;
  localparam logic [7:0] ST_MT_SLA_NACK    = 8'h20;
  localparam logic [7:0] ST_MT_DATA_ACK    = 8'h28;
  localparam logic [7:0] ST_MT_DATA_NACK   = 8'h30;
  localparam logic [7:0] ST_ARB_LOST       = 8'h38;
  localparam logic [7:0] ST_MR_SLA_ACK     = 8'h40;
  localparam logic [7:0] ST_MR_SLA_NACK    = 8'h48;
  localparam logic [7:0] ST_MR_DATA_ACK    = 8'h50;
  localparam logic [7:0] ST_MR_DATA_NACK   = 8'h58;
  localparam logic [7:0] ST_SR_SLA_ACK     = 8'h60;
  localparam logic [7:0] ST_SR_ARB_SLA     = 8'h68;
  localparam logic [7:0] ST_SR_GCALL       = 8'h70;
  localparam logic [7:0] ST_SR_ARB_GCALL   = 8'h78;
  localparam logic [7:0] ST_SR_DATA_ACK    = 8'h80;
  localparam logic [7:0] ST_SR_DATA_NACK   = 8'h88;
  localparam logic [7:0] ST_SR_GDATA_ACK   = 8'h90;
  localparam logic [7:0] ST_SR_GDATA_NACK  = 8'h98;
  localparam logic [7:0] ST_SR_STOP        = 8'hA0;
  localparam logic [7:0] ST_ST_SLA_ACK     = 8'hA8;
  localparam logic [7:0] ST_ST_ARB_SLA     = 8'hB0;
  localparam logic [7:0] ST_ST_DATA_ACK    = 8'hB8;
  localparam logic [7:0] ST_ST_DATA_NACK   = 8'hC0;
  localparam logic [7:0] ST_ST_LAST_ACK    = 8'hC8;
  localparam logic [7:0] ST_NO_INFO        = 8'hF8;
  localparam logic [7:0] ST_UNDEFINED      = 8'hFF;

  // Master transfer modes
  localparam logic [1:0] MODE_WRITE      = 2'd0;
  localparam logic [1:0] MODE_READ       = 2'd1;
  localparam logic [1:0] MODE_WRITE_READ = 2'd2;
  localparam logic [1:0] MODE_BAD        = 2'd3;

  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_IDLE      = 13;
  localparam int HOLD_CYCLES   = 300;

  logic                                  clk;
  logic                                  rst       = 1'b1;
  logic                                  in_valid  = 1'b0;
  logic                                  in_ready;
  i2cms_pkg::in_item_t                   in_item   = '0;
  logic                                  out_valid;
  logic                                  out_ready = 1'b0;
  i2cms_pkg::out_item_t                  out_item;
  logic                                  cfg_valid = 1'b0;
  logic                                  cfg_ready;
  logic [i2cms_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
  logic [i2cms_pkg::CFG_DATA_W-1:0]      cfg_data  = '0;

  // Register mirror
  logic [6:0] reg_target = '0;
  logic [8:0] reg_wcount = '0;
  logic [8:0] reg_rcount = 9'd1;
  logic [8:0] reg_limit  = 9'd256;

  // Predicted sequencer state
  logic [7:0] bus_buffer [i2cms_pkg::BUF_DEPTH];
  logic [8:0] byte_pos       = '0;
  logic       master_dir     = 1'b0;
  logic [1:0] xfer_mode      = MODE_WRITE;
  logic [8:0] tx_len         = '0;
  logic [8:0] rx_len         = '0;
  logic [6:0] own_match      = '0;
  logic       busy           = 1'b0;
  logic [8:0] slave_rx_count = '0;

  i2cms_pkg::out_item_t expected_responses [$];
  int unsigned mismatches        = 0;
  int unsigned items_sent        = 0;
  bit          sender_idles      = 1'b1;
  bit          receiver_idles    = 1'b1;
  int unsigned stall_hold_cycles = 0;

  i2c_master_slave_sequencer dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bytes of buffer in use, clamped to the supported range
  function automatic logic [8:0] limit_now();
    if (reg_limit == 9'd0) return 9'd1;
    return (reg_limit > i2cms_pkg::LIMIT_CAP) ? i2cms_pkg::LIMIT_CAP : reg_limit;
  endfunction

  function automatic logic [8:0] write_len_now();
    logic [8:0] lim;
    lim = limit_now();
    return (reg_wcount > lim) ? lim : reg_wcount;
  endfunction

  // A zero read count acts as one
  function automatic logic [8:0] read_len_now();
    logic [8:0] lim;
    logic [8:0] rc;
    lim = limit_now();
    rc  = (reg_rcount == 9'd0) ? 9'd1 : reg_rcount;
    return (rc > lim) ? lim : rc;
  endfunction

  function automatic int entry_of(logic [8:0] p);
    return int'(p) % i2cms_pkg::BUF_DEPTH;
  endfunction

  function automatic logic [7:0] pop_tx_byte();
    logic [7:0] b;
    b        = bus_buffer[entry_of(byte_pos)];
    byte_pos = byte_pos + 9'd1;
    return b;
  endfunction

  function automatic void push_rx_byte(logic [7:0] b);
    bus_buffer[entry_of(byte_pos)] = b;
    byte_pos = byte_pos + 9'd1;
  endfunction

  // Advance the predicted state by one item and return the response it causes
  function automatic i2cms_pkg::out_item_t predict_bus_response(i2cms_pkg::in_item_t it);
    i2cms_pkg::out_item_t r;
    logic [8:0]           lim;
    r   = '0;
    lim = limit_now();
    case (it.kind)
      i2cms_pkg::KIND_BEGIN: begin
        if (it.transfer_mode != MODE_BAD) begin
          busy      = 1'b1;
          xfer_mode = it.transfer_mode;
          if (it.transfer_mode != MODE_READ) tx_len = write_len_now();
          if (it.transfer_mode != MODE_WRITE) rx_len = read_len_now();
          master_dir    = (it.transfer_mode == MODE_READ);
          r.bus_command = i2cms_pkg::CMD_START;
        end
      end
      i2cms_pkg::KIND_BUF_WRITE: bus_buffer[entry_of(9'(it.buffer_index))] = it.buffer_byte;
      i2cms_pkg::KIND_BUF_READ:  r.read_byte = bus_buffer[entry_of(9'(it.buffer_index))];
      default: begin
        case (it.status_code)
          ST_START, ST_REP_START: begin
            byte_pos      = '0;
            r.send_valid  = 1'b1;
            r.send_byte   = {reg_target, master_dir};
            r.bus_command = i2cms_pkg::CMD_GO_ACK;
          end
          ST_MT_SLA_ACK, ST_MT_DATA_ACK: begin
            if (byte_pos == tx_len) begin
              if (xfer_mode == MODE_WRITE_READ) begin
                master_dir    = 1'b1;
                r.bus_command = i2cms_pkg::CMD_START;
              end else begin
                r.done_valid   = 1'b1;
                r.done_success = 1'b1;
                r.bus_command  = i2cms_pkg::CMD_STOP;
                busy           = 1'b0;
              end
            end else begin
              r.send_valid  = 1'b1;
              r.send_byte   = pop_tx_byte();
              r.bus_command = i2cms_pkg::CMD_TRANSMIT;
            end
          end
          ST_MR_DATA_ACK, ST_MR_SLA_ACK: begin
            if (it.status_code == ST_MR_DATA_ACK) push_rx_byte(it.bus_data);
            r.bus_command = (byte_pos == rx_len - 9'd1) ? i2cms_pkg::CMD_GO_NACK :
                                                          i2cms_pkg::CMD_GO_ACK;
          end
          ST_MR_DATA_NACK: begin
            push_rx_byte(it.bus_data);
            r.done_valid   = 1'b1;
            r.done_success = 1'b1;
            r.bus_command  = i2cms_pkg::CMD_STOP;
            busy           = 1'b0;
          end
          ST_SR_SLA_ACK, ST_SR_ARB_SLA, ST_SR_GCALL, ST_SR_ARB_GCALL: begin
            own_match     = it.bus_data[7:1];
            byte_pos      = '0;
            r.bus_command = i2cms_pkg::CMD_GO_ACK;
          end
          ST_SR_DATA_ACK, ST_SR_GDATA_ACK: begin
            if (byte_pos < lim) push_rx_byte(it.bus_data);
            r.bus_command = i2cms_pkg::CMD_GO_ACK;
          end
          ST_SR_STOP: begin
            slave_rx_count = byte_pos;
            r.done_valid   = 1'b1;
            r.done_success = 1'b1;
            r.done_address = own_match;
            r.bus_command  = i2cms_pkg::CMD_GO_ACK;
          end
          ST_ST_SLA_ACK, ST_ST_ARB_SLA, ST_ST_DATA_ACK: begin
            if (it.status_code != ST_ST_DATA_ACK) begin
              own_match = it.bus_data[7:1];
              byte_pos  = '0;
            end
            if (byte_pos < lim) begin
              r.send_valid = 1'b1;
              r.send_byte  = pop_tx_byte();
            end
            r.bus_command = i2cms_pkg::CMD_GO_ACK;
          end
          ST_SR_DATA_NACK, ST_SR_GDATA_NACK, ST_ST_DATA_NACK, ST_ST_LAST_ACK: begin
            r.bus_command = i2cms_pkg::CMD_GO_ACK;
          end
          ST_MT_SLA_NACK, ST_MT_DATA_NACK, ST_MR_SLA_NACK: begin
            r.done_valid   = 1'b1;
            r.done_status  = it.status_code;
            r.done_address = own_match;
            r.bus_command  = i2cms_pkg::CMD_STOP_START;
          end
          default: r.bus_command = i2cms_pkg::CMD_STOP_START;
        endcase
      end
    endcase
    r.busy_res        = busy;
    r.received_length = slave_rx_count;
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic i2cms_pkg::in_item_t random_item(logic [1:0] kind);
    i2cms_pkg::in_item_t it;
    logic [63:0]         noise;
    noise   = {$urandom, $urandom};
    it      = noise[$bits(i2cms_pkg::in_item_t)-1:0];
    it.kind = kind;
    return it;
  endfunction

  function automatic i2cms_pkg::in_item_t status_item(logic [7:0] code, logic [7:0] data);
    i2cms_pkg::in_item_t it;
    it             = random_item(i2cms_pkg::KIND_STATUS);
    it.status_code = code;
    it.bus_data    = data;
    return it;
  endfunction

  // Offer one item, after a random gap when the sender idles; hold it until accepted, then predict
  task automatic send_item(input i2cms_pkg::in_item_t it);
    int unsigned gap;
    gap = sender_idles ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_responses.push_back(predict_bus_response(it));
    items_sent++;
  endtask

  // Drop valid and wait until every predicted response has come back
  task automatic wait_for_responses();
    in_valid <= 1'b0;
    while (expected_responses.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all four registers; only called while the block is idle
  task automatic load_config(input int unsigned target, input int unsigned wcount,
                             input int unsigned rcount, input int unsigned limit);
    logic [i2cms_pkg::CFG_IDX_W-1:0] order [4];
    int unsigned                     vals  [4];
    order = '{i2cms_pkg::CFG_TARGET_ADDRESS, i2cms_pkg::CFG_WRITE_COUNT,
              i2cms_pkg::CFG_READ_COUNT, i2cms_pkg::CFG_BUFFER_LIMIT};
    vals  = '{target, wcount, rcount, limit};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= order[i];
      cfg_data  <= i2cms_pkg::CFG_DATA_W'(vals[i]);
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (order[i])
        i2cms_pkg::CFG_TARGET_ADDRESS: reg_target = 7'(vals[i]);
        i2cms_pkg::CFG_WRITE_COUNT:    reg_wcount = 9'(vals[i]);
        i2cms_pkg::CFG_READ_COUNT:     reg_rcount = 9'(vals[i]);
        default:                       reg_limit  = 9'(vals[i]);
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // Master write, read or write-then-read, with an occasional refusal
  task automatic run_master_transfer(input logic [1:0] mode);
    i2cms_pkg::in_item_t it;
    int unsigned         wc;
    int unsigned         rc;
    logic [7:0]          aborts [4];
    aborts = '{ST_MT_SLA_NACK, ST_MT_DATA_NACK, ST_MR_SLA_NACK, ST_ARB_LOST};
    wc = write_len_now();
    rc = read_len_now();
    it = random_item(i2cms_pkg::KIND_BEGIN);
    it.transfer_mode = mode;
    send_item(it);
    send_item(status_item(ST_START, 8'($urandom)));
    if (mode != MODE_READ) begin
      send_item(status_item(ST_MT_SLA_ACK, 8'($urandom)));
      for (int k = 0; k < wc; k++) begin
        if ($urandom_range(0, 39) == 0) begin
          send_item(status_item(aborts[$urandom_range(0, 3)], 8'($urandom)));
          return;
        end
        send_item(status_item(ST_MT_DATA_ACK, 8'($urandom)));
      end
      // last acknowledge ends the write or turns the bus around
      send_item(status_item(ST_MT_DATA_ACK, 8'($urandom)));
      if (mode == MODE_WRITE) return;
      send_item(status_item(ST_REP_START, 8'($urandom)));
    end
    if ($urandom_range(0, 15) == 0) begin
      send_item(status_item(ST_MR_SLA_NACK, 8'($urandom)));
      return;
    end
    send_item(status_item(ST_MR_SLA_ACK, 8'($urandom)));
    for (int k = 1; k < rc; k++) send_item(status_item(ST_MR_DATA_ACK, 8'($urandom)));
    send_item(status_item(ST_MR_DATA_NACK, 8'($urandom)));
  endtask

  // Slave receive, sometimes running past the buffer limit
  task automatic run_slave_receive();
    logic [7:0]  addr_codes [4];
    logic [7:0]  data_codes [6];
    int unsigned lim;
    int unsigned n;
    addr_codes = '{ST_SR_SLA_ACK, ST_SR_ARB_SLA, ST_SR_GCALL, ST_SR_ARB_GCALL};
    data_codes = '{ST_SR_DATA_ACK, ST_SR_GDATA_ACK, ST_SR_DATA_ACK, ST_SR_GDATA_ACK,
                   ST_SR_DATA_NACK, ST_SR_GDATA_NACK};
    lim = limit_now();
    n   = $urandom_range(0, (lim < 10) ? lim + 2 : 10);
    send_item(status_item(addr_codes[$urandom_range(0, 3)], 8'($urandom)));
    repeat (n) send_item(status_item(data_codes[$urandom_range(0, 5)], 8'($urandom)));
    send_item(status_item(ST_SR_STOP, 8'($urandom)));
  endtask

  // Slave transmit, sometimes running past the buffer limit
  task automatic run_slave_transmit();
    int unsigned lim;
    int unsigned n;
    lim = limit_now();
    n   = $urandom_range(0, (lim < 10) ? lim + 2 : 10);
    send_item(status_item($urandom_range(0, 1) ? ST_ST_SLA_ACK : ST_ST_ARB_SLA,
                          8'($urandom)));
    repeat (n) send_item(status_item(ST_ST_DATA_ACK, 8'($urandom)));
    send_item(status_item($urandom_range(0, 1) ? ST_ST_DATA_NACK : ST_ST_LAST_ACK,
                          8'($urandom)));
  endtask

  task automatic run_random_phase(input int unsigned budget);
    int unsigned stop_at;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0:       run_master_transfer(MODE_WRITE);
        1:       run_master_transfer(MODE_READ);
        2:       run_master_transfer(MODE_WRITE_READ);
        3, 4:    run_slave_receive();
        5, 6:    run_slave_transmit();
        default: send_item(random_item(2'($urandom_range(0, 3))));
      endcase
    end
    wait_for_responses();
  endtask

  // Write every buffer entry so that later reads never see an unwritten one
  task automatic test_buffer_fill();
    i2cms_pkg::in_item_t it;
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
    for (int e = 0; e < i2cms_pkg::BUF_DEPTH; e++) begin
      it = random_item(i2cms_pkg::KIND_BUF_WRITE);
      it.buffer_index = 8'(e);
      send_item(it);
    end
    wait_for_responses();
  endtask

  task automatic test_directed_cases();
    i2cms_pkg::in_item_t it;
    // limit above range clamps, zero read count acts as one
    load_config(7'h7F, 1, 0, 511);
    it = random_item(i2cms_pkg::KIND_BUF_WRITE);
    it.buffer_index = 8'hFF;
    it.buffer_byte  = 8'hFF;
    send_item(it);
    it.buffer_index = 8'h00;
    it.buffer_byte  = 8'h00;
    send_item(it);
    it = random_item(i2cms_pkg::KIND_BUF_READ);
    it.buffer_index = 8'hFF;
    send_item(it);
    it.buffer_index = 8'h00;
    send_item(it);
    // unknown transfer mode is ignored
    it = random_item(i2cms_pkg::KIND_BEGIN);
    it.transfer_mode = MODE_BAD;
    send_item(it);
    // write one byte, turn around with a repeated start, read one byte
    it.transfer_mode = MODE_WRITE_READ;
    send_item(it);
    send_item(status_item(ST_START, 8'h00));
    send_item(status_item(ST_MT_SLA_ACK, 8'hFF));
    send_item(status_item(ST_MT_DATA_ACK, 8'h00));
    send_item(status_item(ST_MT_DATA_ACK, 8'hFF));
    send_item(status_item(ST_REP_START, 8'h00));
    send_item(status_item(ST_MR_SLA_ACK, 8'hFF));
    send_item(status_item(ST_MR_DATA_NACK, 8'hFF));
    // begin while busy replaces the transfer; then the address is refused
    it.transfer_mode = MODE_READ;
    send_item(it);
    it.transfer_mode = MODE_WRITE;
    send_item(it);
    send_item(status_item(ST_MT_SLA_NACK, 8'hA5));
    // arbitration lost, bus error and codes outside the table
    send_item(status_item(ST_ARB_LOST, 8'h00));
    send_item(status_item(ST_BUS_ERROR, 8'hFF));
    send_item(status_item(ST_UNDEFINED, 8'h00));
    // slave receive then slave transmit
    send_item(status_item(ST_SR_SLA_ACK, 8'hFF));
    send_item(status_item(ST_SR_DATA_ACK, 8'h5A));
    send_item(status_item(ST_SR_STOP, 8'h00));
    send_item(status_item(ST_ST_SLA_ACK, 8'h00));
    send_item(status_item(ST_ST_DATA_ACK, 8'hFF));
    send_item(status_item(ST_ST_DATA_NACK, 8'h00));
    wait_for_responses();
  endtask

  // Hold off the output for a long stretch while items keep coming
  task automatic test_output_stall();
    sender_idles      = 1'b0;
    receiver_idles    = 1'b0;
    stall_hold_cycles = HOLD_CYCLES;
    repeat (40) send_item(random_item(i2cms_pkg::KIND_BUF_READ));
    wait_for_responses();
  endtask

  // Stream received bytes past the buffer depth so that entries wrap around
  task automatic test_position_wrap();
    i2cms_pkg::in_item_t it;
    load_config(7'h2A, 300, 511, 256);
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    it = random_item(i2cms_pkg::KIND_BEGIN);
    it.transfer_mode = MODE_READ;
    send_item(it);
    send_item(status_item(ST_START, 8'($urandom)));
    send_item(status_item(ST_MR_SLA_ACK, 8'($urandom)));
    repeat (260) send_item(status_item(ST_MR_DATA_ACK, 8'($urandom)));
    send_item(status_item(ST_MR_DATA_NACK, 8'($urandom)));
    wait_for_responses();
  endtask

  task automatic test_random_traffic();
    load_config($urandom_range(0, 127), 3, 4, 256);
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
    run_random_phase(70);

    load_config(0, 0, 1, 1);
    sender_idles   = 1'b0;
    receiver_idles = 1'b1;
    run_random_phase(50);

    load_config(127, 5, 0, 3);
    sender_idles   = 1'b1;
    receiver_idles = 1'b0;
    run_random_phase(60);

    load_config($urandom_range(0, 127), 9, 12, 511);
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    run_random_phase(70);

    load_config($urandom_range(0, 127), $urandom_range(0, 8), $urandom_range(0, 8), 0);
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
    run_random_phase(50);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_buffer_fill();
    test_directed_cases();
    test_output_stall();
    test_position_wrap();
    test_random_traffic();
    wait_for_responses();
    if (mismatches == 0 && expected_responses.size() == 0) begin
      $display("i2c_master_slave_sequencer: match");
    end else begin
      $display("i2c_master_slave_sequencer: mismatch");
    end
    $finish;
  end

  // Accept responses, with random stalls when the receiver idles, and compare each with the oldest prediction
  initial begin : response_checker
    i2cms_pkg::out_item_t want;
    int unsigned          stall;
    while (rst) @(posedge clk);
    forever begin
      if (stall_hold_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (stall_hold_cycles) @(posedge clk);
        stall_hold_cycles = 0;
      end
      stall = receiver_idles ? $urandom_range(0, MAX_IDLE) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (expected_responses.size() == 0) begin
        $error("response with no item pending");
        mismatches++;
      end else begin
        want = expected_responses.pop_front();
        check_field("bus_command", want.bus_command, out_item.bus_command);
        check_field("send_valid", want.send_valid, out_item.send_valid);
        check_field("send_byte", want.send_byte, out_item.send_byte);
        check_field("done_valid", want.done_valid, out_item.done_valid);
        check_field("done_success", want.done_success, out_item.done_success);
        check_field("done_status", want.done_status, out_item.done_status);
        check_field("done_address", want.done_address, out_item.done_address);
        check_field("busy_res", want.busy_res, out_item.busy_res);
        check_field("received_length", want.received_length, out_item.received_length);
        check_field("read_byte", want.read_byte, out_item.read_byte);
      end
    end
  end

  // Guard against a hung handshake
  initial begin
    #3000000;
    $display("i2c_master_slave_sequencer: mismatch");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/i2cms_pkg.sv
hw/rtl/i2cms_ram.sv
hw/rtl/i2c_master_slave_sequencer.sv
hw/rtl/i2cms_check.sv
tb/sv/tb_top.sv
